FILE: hw/rtl/ttm_pkg.sv
package ttm_pkg;

	// item field widths
	localparam int FIELD_W = 24;
	localparam int ANGLE_W = 19;
	localparam int CFG_W = 3;

	// enable bit positions in transform_enables
	localparam int EN_TRANS = 0;
	localparam int EN_ROT = 1;
	localparam int EN_SCALE = 2;

	// parameter defaults
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES = 24;

	// angle and cordic vector width, Q30 radians
	localparam int ZW = 34;
	localparam logic signed [ZW-1:0] Q30_PI = 34'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [ZW-1:0] Q30_TWO_PI = 34'sd6746518852;
	localparam logic signed [ZW-1:0] Q30_GAIN = 34'sd652032874;

	// per-item control travelling down the pipeline
	typedef struct packed {
		logic vld;
		logic trans;
		logic rot;
		logic scl;
	} ctrl_t;

	// arctangent of 2^-idx in Q30
	function automatic logic signed [ZW-1:0] atan_q30(input int idx);
		logic signed [ZW-1:0] r;
		case (idx)
			0: r = 34'sd843314857;
			1: r = 34'sd497837830;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clamp to the signed output field range
	function automatic logic [FIELD_W-1:0] sat_field(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic [FIELD_W-1:0] r;
		hi = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
		lo = -(64'sd1 <<< (FIELD_W - 1));
		if (v > hi) begin
			r = hi[FIELD_W-1:0];
		end else if (v < lo) begin
			r = lo[FIELD_W-1:0];
		end else begin
			r = v[FIELD_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/ttm_reduce_cell.sv
module ttm_reduce_cell #(
	parameter int RW = 34,
	parameter int SW = 1,
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [RW-1:0] in_r,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [RW-1:0] out_r,
	output logic [SW-1:0] out_side
);

	// two pi scaled by 2^K
	localparam logic [RW-1:0] STEP = RW'(ttm_pkg::Q30_TWO_PI) << K;

	logic          take;
	logic [RW-1:0] r_nx;
	logic          vld_q;
	logic [RW-1:0] r_q;
	logic [SW-1:0] side_q;

	// one restoring remainder step
	assign take = (in_r >= STEP);
	assign r_nx = take ? (in_r - STEP) : in_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		r_q <= r_nx;
		side_q <= in_side;
	end

	assign out_vld = vld_q;
	assign out_r = r_q;
	assign out_side = side_q;

endmodule

FILE: hw/rtl/ttm_cordic_cell.sv
module ttm_cordic_cell #(
	parameter int SW = 1,
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	input  logic signed [ttm_pkg::ZW-1:0]   in_x,
	input  logic signed [ttm_pkg::ZW-1:0]   in_y,
	input  logic signed [ttm_pkg::ZW-1:0]   in_z,
	input  logic [SW-1:0]                   in_side,
	output logic                            out_vld,
	output logic signed [ttm_pkg::ZW-1:0]   out_x,
	output logic signed [ttm_pkg::ZW-1:0]   out_y,
	output logic signed [ttm_pkg::ZW-1:0]   out_z,
	output logic [SW-1:0]                   out_side
);

	localparam logic signed [ttm_pkg::ZW-1:0] ATAN = ttm_pkg::atan_q30(IDX);

	logic                          rot_pos;
	logic signed [ttm_pkg::ZW-1:0] x_nx;
	logic signed [ttm_pkg::ZW-1:0] y_nx;
	logic signed [ttm_pkg::ZW-1:0] z_nx;
	logic                          vld_q;
	logic signed [ttm_pkg::ZW-1:0] x_q;
	logic signed [ttm_pkg::ZW-1:0] y_q;
	logic signed [ttm_pkg::ZW-1:0] z_q;
	logic [SW-1:0]                 side_q;

	// one micro-rotation, direction from the residual angle sign
	assign rot_pos = ~in_z[ttm_pkg::ZW-1];

	always_comb begin
		if (rot_pos) begin
			x_nx = in_x - (in_y >>> IDX);
			y_nx = in_y + (in_x >>> IDX);
			z_nx = in_z - ATAN;
		end else begin
			x_nx = in_x + (in_y >>> IDX);
			y_nx = in_y - (in_x >>> IDX);
			z_nx = in_z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_nx;
		y_q <= y_nx;
		z_q <= z_nx;
		side_q <= in_side;
	end

	assign out_vld = vld_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign out_z = z_q;
	assign out_side = side_q;

endmodule

FILE: hw/rtl/ttm_rotate.sv
module ttm_rotate #(
	parameter int FRAC_BITS = ttm_pkg::FRAC_BITS_DEF,
	parameter int BW = 33,
	parameter int CW = 18
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ttm_pkg::ctrl_t                   ctrl,
	input  logic signed [BW-1:0]             b11,
	input  logic signed [BW-1:0]             b22,
	input  logic signed [BW-1:0]             b31,
	input  logic signed [BW-1:0]             b32,
	input  logic signed [CW-1:0]             cos_v,
	input  logic signed [CW-1:0]             sin_v,
	output logic                             done,
	output logic [ttm_pkg::FIELD_W-1:0]      m11,
	output logic [ttm_pkg::FIELD_W-1:0]      m12,
	output logic [ttm_pkg::FIELD_W-1:0]      m21,
	output logic [ttm_pkg::FIELD_W-1:0]      m22,
	output logic [ttm_pkg::FIELD_W-1:0]      m31,
	output logic [ttm_pkg::FIELD_W-1:0]      m32
);

	localparam int PW = BW + CW + 1;
	localparam int RDW = PW - FRAC_BITS;
	localparam int NPROD = 8;
	localparam int P11C = 0;
	localparam int P11S = 1;
	localparam int P22N = 2;
	localparam int P22C = 3;
	localparam int P31C = 4;
	localparam int P31S = 5;
	localparam int P32C = 6;
	localparam int P32S = 7;
	localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] HALF_64 = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [CW:0]       c_ext;
	logic signed [CW:0]       s_ext;
	logic signed [CW:0]       ns_ext;
	logic signed [PW-1:0]     prod_s1 [NPROD];
	logic signed [BW-1:0]     b11_s1, b22_s1, b31_s1, b32_s1;
	ttm_pkg::ctrl_t           ctrl_s1;
	logic signed [PW-1:0]     rsum [NPROD];
	logic signed [RDW-1:0]    rnd_s2 [NPROD];
	logic signed [BW-1:0]     b11_s2, b22_s2, b31_s2, b32_s2;
	ttm_pkg::ctrl_t           ctrl_s2;
	logic                     pivot;
	logic signed [63:0]       v11, v12, v21, v22, v31, v32;
	logic                     done_q;
	logic [ttm_pkg::FIELD_W-1:0] m11_q, m12_q, m21_q, m22_q, m31_q, m32_q;

	// sine and cosine widened so that the negated sine cannot wrap
	assign c_ext = (CW+1)'(cos_v);
	assign s_ext = (CW+1)'(sin_v);
	assign ns_ext = -s_ext;

	// control through the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			done_q <= ctrl_s2.vld;
		end
	end

	// stage 1: the eight rotation products
	always_ff @(posedge clk) begin
		prod_s1[P11C] <= b11 * c_ext;
		prod_s1[P11S] <= b11 * s_ext;
		prod_s1[P22N] <= b22 * ns_ext;
		prod_s1[P22C] <= b22 * c_ext;
		prod_s1[P31C] <= b31 * c_ext;
		prod_s1[P31S] <= b31 * s_ext;
		prod_s1[P32C] <= b32 * c_ext;
		prod_s1[P32S] <= b32 * s_ext;
		b11_s1 <= b11;
		b22_s1 <= b22;
		b31_s1 <= b31;
		b32_s1 <= b32;
	end

	// round to nearest, ties up
	always_comb begin
		for (int i = 0; i < NPROD; i++) begin
			rsum[i] = prod_s1[i] + HALF_P;
		end
	end

	// stage 2: rounded products
	always_ff @(posedge clk) begin
		for (int i = 0; i < NPROD; i++) begin
			rnd_s2[i] <= $signed(rsum[i][PW-1:FRAC_BITS]);
		end
		b11_s2 <= b11_s1;
		b22_s2 <= b22_s1;
		b31_s2 <= b31_s1;
		b32_s2 <= b32_s1;
	end

	// combine, pivot back to the center
	assign pivot = ctrl_s2.rot | ctrl_s2.scl;

	always_comb begin
		if (ctrl_s2.rot) begin
			v11 = 64'(rnd_s2[P11C]);
			v12 = 64'(rnd_s2[P11S]);
			v21 = 64'(rnd_s2[P22N]);
			v22 = 64'(rnd_s2[P22C]);
			v31 = 64'(rnd_s2[P31C]) - 64'(rnd_s2[P32S]);
			v32 = 64'(rnd_s2[P31S]) + 64'(rnd_s2[P32C]);
		end else begin
			v11 = 64'(b11_s2);
			v12 = '0;
			v21 = '0;
			v22 = 64'(b22_s2);
			v31 = 64'(b31_s2);
			v32 = 64'(b32_s2);
		end
		if (pivot) begin
			v31 = v31 + HALF_64;
			v32 = v32 + HALF_64;
		end
	end

	// stage 3: saturated result registers
	always_ff @(posedge clk) begin
		m11_q <= ttm_pkg::sat_field(v11);
		m12_q <= ttm_pkg::sat_field(v12);
		m21_q <= ttm_pkg::sat_field(v21);
		m22_q <= ttm_pkg::sat_field(v22);
		m31_q <= ttm_pkg::sat_field(v31);
		m32_q <= ttm_pkg::sat_field(v32);
	end

	assign done = done_q;
	assign m11 = m11_q;
	assign m12 = m12_q;
	assign m21 = m21_q;
	assign m22 = m22_q;
	assign m31 = m31_q;
	assign m32 = m32_q;

	// without rotation the shear entries stay zero
	a_no_rot_shear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s2.vld && !ctrl_s2.rot) |=> (m12 == '0 && m21 == '0))
		else $error("shear entries nonzero with rotation off");

	// nothing enabled leaves a zero offset
	a_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s2.vld && !ctrl_s2.trans && !ctrl_s2.rot && !ctrl_s2.scl)
		|=> (m31 == '0 && m32 == '0))
		else $error("offset nonzero with all parts disabled");

endmodule

FILE: hw/rtl/texture_transform_matrix.sv
// Texture transform matrix generator. One item is accepted on every clock
// at which start is high (busy stays low), and its six matrix entries appear
// on m11..m32 with a one-cycle done strobe after stages 1 to 3, the R
// angle-reduction cells (16 - FRAC_BITS when FRAC_BITS is below 15, else 1),
// stages 4 and 5, the N = min(CORDIC_STAGES, 24) CORDIC cells, stage 6 and
// the stages of ttm_rotate. The sustained rate is one item per clock: every
// stage, the reduction cells and the CORDIC cells take a new item each cycle.
// There is no back-pressure: the receiver must take each result in the cycle
// that done is high. transform_enables is written through cfg_we/cfg_wdata
// and may only change while no item is in flight.
module texture_transform_matrix #(
	parameter int FRAC_BITS = ttm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = ttm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ttm_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ttm_pkg::FIELD_W-1:0]  trans_x,
	input  logic signed [ttm_pkg::FIELD_W-1:0]  trans_y,
	input  logic signed [ttm_pkg::ANGLE_W-1:0]  angle,
	input  logic signed [ttm_pkg::FIELD_W-1:0]  scale_x,
	input  logic signed [ttm_pkg::FIELD_W-1:0]  scale_y,
	output logic                                done,
	output logic [ttm_pkg::FIELD_W-1:0]         m11,
	output logic [ttm_pkg::FIELD_W-1:0]         m12,
	output logic [ttm_pkg::FIELD_W-1:0]         m21,
	output logic [ttm_pkg::FIELD_W-1:0]         m22,
	output logic [ttm_pkg::FIELD_W-1:0]         m31,
	output logic [ttm_pkg::FIELD_W-1:0]         m32
);

	localparam int FW = ttm_pkg::FIELD_W;
	localparam int ZW = ttm_pkg::ZW;
	localparam int RED_STEPS = (FRAC_BITS < 15) ? (16 - FRAC_BITS) : 1;
	localparam int RW = ((49 - FRAC_BITS) > 34) ? (49 - FRAC_BITS) : 34;
	localparam int NCS = (CORDIC_STAGES < ttm_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : ttm_pkg::ATAN_ENTRIES;
	localparam int AW = 26;
	localparam int PRW = AW + FW;
	localparam int BW = ((49 - FRAC_BITS) > 26) ? (49 - FRAC_BITS) : 26;
	localparam int CW = FRAC_BITS + 2;
	localparam int MW = ttm_pkg::CFG_W + 4 * BW;
	localparam int SW = MW + 1;
	localparam int CRW = ZW - 30 + FRAC_BITS;
	localparam int LAT = 9 + RED_STEPS + NCS;
	localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [BW-1:0] ONE_B = BW'(1) <<< FRAC_BITS;
	localparam logic signed [PRW-1:0] HALF_P = PRW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ZW-1:0] RND_C = ZW'(1) <<< (29 - FRAC_BITS);

	logic [ttm_pkg::CFG_W-1:0] enables_q;

	ttm_pkg::ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [FW-1:0] tx_s1, ty_s1, sx_s1, sy_s1;
	logic signed [ttm_pkg::ANGLE_W-1:0] ang_s1;

	logic                 pivot_s1;
	logic signed [AW-1:0] base_a;
	logic signed [AW-1:0] a31, a32;
	logic [ttm_pkg::ANGLE_W-1:0] ang_mag;
	logic signed [PRW-1:0] prod31_s2, prod32_s2;
	logic signed [AW-1:0] a31_s2, a32_s2;
	logic signed [FW-1:0] sx_s2, sy_s2;
	logic                 neg_s2;
	logic [RW-1:0]        mag_s2;

	logic signed [PRW-1:0] t31, t32;
	logic signed [BW-1:0] b11_s3, b22_s3, b31_s3, b32_s3;
	logic                 neg_s3;
	logic [RW-1:0]        mag_s3;

	logic                 red_vld  [RED_STEPS+1];
	logic [RW-1:0]        red_r    [RED_STEPS+1];
	logic [SW-1:0]        red_side [RED_STEPS+1];

	logic signed [ZW-1:0] z_red, z_sgn, z_wrap;
	logic                 v_s4;
	logic signed [ZW-1:0] z_s4;
	logic [MW-1:0]        main_s4;

	logic signed [ZW-1:0] z_fold;
	logic                 flip_nx;
	logic                 v_s5;
	logic signed [ZW-1:0] z_s5;
	logic                 flip_s5;
	logic [MW-1:0]        main_s5;

	logic                 cv    [NCS+1];
	logic signed [ZW-1:0] cx    [NCS+1];
	logic signed [ZW-1:0] cy    [NCS+1];
	logic signed [ZW-1:0] cz    [NCS+1];
	logic [SW-1:0]        cside [NCS+1];

	logic                 flip_out;
	logic signed [ZW-1:0] xf, yf, xt, yt;
	logic                 v_s6;
	logic signed [CW-1:0] c_s6, s_s6;
	logic [MW-1:0]        main_s6;
	ttm_pkg::ctrl_t       rot_ctrl;
	logic [ttm_pkg::CFG_W-1:0] en_s6;

	assign busy = 1'b0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q <= '0;
		end else if (cfg_we) begin
			enables_q <= cfg_wdata;
		end
	end

	// item control through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1.vld <= start & ~busy;
			ctrl_s1.trans <= enables_q[ttm_pkg::EN_TRANS];
			ctrl_s1.rot <= enables_q[ttm_pkg::EN_ROT];
			ctrl_s1.scl <= enables_q[ttm_pkg::EN_SCALE];
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// stage 1: capture the item
	always_ff @(posedge clk) begin
		tx_s1 <= trans_x;
		ty_s1 <= trans_y;
		ang_s1 <= angle;
		sx_s1 <= scale_x;
		sy_s1 <= scale_y;
	end

	// stage 2: offset before scaling, scale products, angle magnitude
	assign pivot_s1 = ctrl_s1.rot | ctrl_s1.scl;
	assign base_a = pivot_s1 ? -HALF_A : '0;
	assign a31 = base_a - (ctrl_s1.trans ? AW'(tx_s1) : '0);
	assign a32 = base_a + (ctrl_s1.trans ? AW'(ty_s1) : '0);
	assign ang_mag = ang_s1[ttm_pkg::ANGLE_W-1] ?
		ttm_pkg::ANGLE_W'(-ang_s1) : ang_s1;

	always_ff @(posedge clk) begin
		prod31_s2 <= a31 * sx_s1;
		prod32_s2 <= a32 * sy_s1;
		a31_s2 <= a31;
		a32_s2 <= a32;
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		neg_s2 <= ang_s1[ttm_pkg::ANGLE_W-1];
		mag_s2 <= RW'(ang_mag) << (30 - FRAC_BITS);
	end

	// stage 3: linear part and offset after the optional scale
	assign t31 = prod31_s2 + HALF_P;
	assign t32 = prod32_s2 + HALF_P;

	always_ff @(posedge clk) begin
		if (ctrl_s2.scl) begin
			b11_s3 <= BW'(sx_s2);
			b22_s3 <= BW'(sy_s2);
			b31_s3 <= BW'($signed(t31[PRW-1:FRAC_BITS]));
			b32_s3 <= BW'($signed(t32[PRW-1:FRAC_BITS]));
		end else begin
			b11_s3 <= ONE_B;
			b22_s3 <= ONE_B;
			b31_s3 <= BW'(a31_s2);
			b32_s3 <= BW'(a32_s2);
		end
		neg_s3 <= neg_s2;
		mag_s3 <= mag_s2;
	end

	// angle magnitude modulo two pi, one scaled step per cell
	assign red_vld[0] = ctrl_s3.vld;
	assign red_r[0] = mag_s3;
	assign red_side[0] = {neg_s3, ctrl_s3.scl, ctrl_s3.rot, ctrl_s3.trans,
		b11_s3, b22_s3, b31_s3, b32_s3};

	for (genvar gi = 0; gi < RED_STEPS; gi++) begin : g_red
		ttm_reduce_cell #(
			.RW(RW),
			.SW(SW),
			.K(RED_STEPS - 1 - gi)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_vld(red_vld[gi]),
			.in_r(red_r[gi]),
			.in_side(red_side[gi]),
			.out_vld(red_vld[gi+1]),
			.out_r(red_r[gi+1]),
			.out_side(red_side[gi+1])
		);
	end

	// stage 4: restore the sign and wrap into minus pi .. pi
	assign z_red = $signed(red_r[RED_STEPS][ZW-1:0]);
	assign z_sgn = red_side[RED_STEPS][MW] ? -z_red : z_red;

	always_comb begin
		if (z_sgn > ttm_pkg::Q30_PI) begin
			z_wrap = z_sgn - ttm_pkg::Q30_TWO_PI;
		end else if (z_sgn < -ttm_pkg::Q30_PI) begin
			z_wrap = z_sgn + ttm_pkg::Q30_TWO_PI;
		end else begin
			z_wrap = z_sgn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= red_vld[RED_STEPS];
			v_s5 <= v_s4;
			v_s6 <= cv[NCS];
		end
	end

	always_ff @(posedge clk) begin
		z_s4 <= z_wrap;
		main_s4 <= red_side[RED_STEPS][MW-1:0];
	end

	// stage 5: fold into minus pi/2 .. pi/2, flipping the result sign
	always_comb begin
		if (z_s4 > ttm_pkg::Q30_HALF_PI) begin
			z_fold = z_s4 - ttm_pkg::Q30_PI;
			flip_nx = 1'b1;
		end else if (z_s4 < -ttm_pkg::Q30_HALF_PI) begin
			z_fold = z_s4 + ttm_pkg::Q30_PI;
			flip_nx = 1'b1;
		end else begin
			z_fold = z_s4;
			flip_nx = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		z_s5 <= z_fold;
		flip_s5 <= flip_nx;
		main_s5 <= main_s4;
	end

	// cordic rotation cells
	assign cv[0] = v_s5;
	assign cx[0] = ttm_pkg::Q30_GAIN;
	assign cy[0] = '0;
	assign cz[0] = z_s5;
	assign cside[0] = {flip_s5, main_s5};

	for (genvar gc = 0; gc < NCS; gc++) begin : g_cordic
		ttm_cordic_cell #(
			.SW(SW),
			.IDX(gc)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_vld(cv[gc]),
			.in_x(cx[gc]),
			.in_y(cy[gc]),
			.in_z(cz[gc]),
			.in_side(cside[gc]),
			.out_vld(cv[gc+1]),
			.out_x(cx[gc+1]),
			.out_y(cy[gc+1]),
			.out_z(cz[gc+1]),
			.out_side(cside[gc+1])
		);
	end

	// stage 6: unfold and round sine and cosine to the fraction width
	assign flip_out = cside[NCS][MW];
	assign xf = flip_out ? -cx[NCS] : cx[NCS];
	assign yf = flip_out ? -cy[NCS] : cy[NCS];
	assign xt = xf + RND_C;
	assign yt = yf + RND_C;

	always_ff @(posedge clk) begin
		c_s6 <= CW'($signed(xt[ZW-1:ZW-CRW]));
		s_s6 <= CW'($signed(yt[ZW-1:ZW-CRW]));
		main_s6 <= cside[NCS][MW-1:0];
	end

	// rotation, pivot and saturation
	assign en_s6 = main_s6[MW-1 -: ttm_pkg::CFG_W];
	assign rot_ctrl.vld = v_s6;
	assign rot_ctrl.trans = en_s6[0];
	assign rot_ctrl.rot = en_s6[1];
	assign rot_ctrl.scl = en_s6[2];

	ttm_rotate #(
		.FRAC_BITS(FRAC_BITS),
		.BW(BW),
		.CW(CW)
	) u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(rot_ctrl),
		.b11($signed(main_s6[4*BW-1 -: BW])),
		.b22($signed(main_s6[3*BW-1 -: BW])),
		.b31($signed(main_s6[2*BW-1 -: BW])),
		.b32($signed(main_s6[BW-1:0])),
		.cos_v(c_s6),
		.sin_v(s_s6),
		.done(done),
		.m11(m11),
		.m12(m12),
		.m21(m21),
		.m22(m22),
		.m31(m31),
		.m32(m32)
	);

	// every accepted item produces a done strobe
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item produced no result at the expected cycle");

	// no result without an item accepted at the matching cycle
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching item");

endmodule
